// File: rtl/core/pdp_pkg.sv
// shared types and constants of the phase dimmer playback unit
`timescale 1ns / 1ps
`default_nettype none

package pdp_pkg;

    // sizing
    localparam int CHANNELS  = 8;
    localparam int SAMPLES   = 4096;
    localparam int LEVEL_FS  = 255;

    // field widths
    localparam int MODE_W    = 3;
    localparam int CH_W      = 3;
    localparam int IDX_W     = 12;
    localparam int LVL_W     = 8;
    localparam int PLAY_W    = 2;
    localparam int POS_W     = 12;
    localparam int PHASE_W   = 16;
    localparam int SCNT_W    = 13;

    // port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_BITS    = CH_W + IDX_W + LVL_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = CHANNELS + PLAY_W + POS_W + PHASE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // table memory
    localparam int SMP_W     = $clog2(SAMPLES);
    localparam int MEM_AW    = CH_W + SMP_W;
    localparam int MEM_DEPTH = CHANNELS * SAMPLES;
    localparam int CNT_W     = $clog2(CHANNELS + 1);

    // limits
    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
    localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
    localparam logic [LVL_W-1:0]   LEVEL_FS_L = LVL_W'(LEVEL_FS);

    // divide by full scale through a reciprocal
    localparam int PROD_W    = 2 * LVL_W;
    localparam int RECIP_SH  = 24;
    localparam int RECIP     = (1 << RECIP_SH) / LEVEL_FS + 1;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int SCALED_W  = PROD_W + RECIP_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_LO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_HI      = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PHASE = 3'd0,
        MODE_SYNC  = 3'd1,
        MODE_MS    = 3'd2,
        MODE_LOAD  = 3'd3,
        MODE_PLAY  = 3'd4,
        MODE_PAUSE = 3'd5,
        MODE_STOP  = 3'd6
    } mode_t;

    typedef enum logic [PLAY_W-1:0] {
        PLAY_STOPPED = 2'd0,
        PLAY_RUNNING = 2'd1,
        PLAY_PAUSED  = 2'd2
    } play_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        logic             vld;
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] level;
    } scale_req_t;

    typedef struct packed {
        logic             vld;
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] quot;
    } scale_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/pdp_fire_scale.sv
// level to fire offset pipeline: (full scale - level) * span / full scale
`timescale 1ns / 1ps
`default_nettype none

module pdp_fire_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdp_pkg::scale_req_t           req,
    input  logic [pdp_pkg::LVL_W-1:0]     span,
    output pdp_pkg::scale_rsp_t           rsp,
    output logic                          busy
);
    import pdp_pkg::*;

    logic [LVL_W-1:0]    lvl_clamped;
    logic [PROD_W-1:0]   prod_next;
    logic [SCALED_W-1:0] scaled;

    logic                s1_vld_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic                s2_vld_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic [LVL_W-1:0]    s2_quot_reg;

    always_comb
    begin
        lvl_clamped = (req.level > LEVEL_FS_L) ? LEVEL_FS_L : req.level;
        prod_next   = PROD_W'(LEVEL_FS_L - lvl_clamped) * PROD_W'(span);
        scaled      = SCALED_W'(s1_prod_reg) * SCALED_W'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= req.vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg   <= req.ch;
        s1_prod_reg <= prod_next;
        s2_ch_reg   <= s1_ch_reg;
        s2_quot_reg <= scaled[RECIP_SH +: LVL_W];
    end

    assign rsp.vld  = s2_vld_reg;
    assign rsp.ch   = s2_ch_reg;
    assign rsp.quot = s2_quot_reg;
    assign busy     = s1_vld_reg | s2_vld_reg;

endmodule

`default_nettype wire

// File: rtl/core/phase_dimmer_playback_unit.sv
// top level of the multichannel phase dimmer with stored brightness playback
// timing: an item is captured, executed and then loaded into the output register once that
//   register is free; a sync edge with playback enabled adds a table sweep before the load
// throughput: a new item is taken only after the last one is loaded into the output register;
//   a sweeping sync edge reads the table one entry a cycle
// reset: async active low; play state stopped, counters, pins and fire counts zero
`timescale 1ns / 1ps
`default_nettype none

module phase_dimmer_playback_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // channel, sample_index, level (from bit 0 up)
    input  logic [pdp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic [pdp_pkg::MODE_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pins, play_state, position, phase_count (from bit 0 up)
    output logic [pdp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [pdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdp_pkg::*;

    // sequencer
    fsm_t state_reg, state_next;

    // captured item
    mode_t            item_mode_reg;
    logic [CH_W-1:0]  item_ch_reg;
    logic [IDX_W-1:0] item_idx_reg;
    logic [LVL_W-1:0] item_lvl_reg;

    // configuration
    logic [SCNT_W-1:0] sample_count_reg;
    logic [LVL_W-1:0]  fire_lo_reg;
    logic [LVL_W-1:0]  fire_hi_reg;

    // playback state
    play_t              play_reg;
    logic [POS_W-1:0]   position_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [CHANNELS-1:0] pins_reg;
    logic [LVL_W-1:0]   fire_reg [CHANNELS];

    // table sweep
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             rd_vld_reg;
    logic [CH_W-1:0]  rd_ch_reg;
    logic [LVL_W-1:0] rd_data_reg;

    // brightness table, one row of SAMPLES per channel
    logic [LVL_W-1:0] table_mem [MEM_DEPTH];
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;

    // output register
    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // control from the sequencer
    logic exec_en;
    logic issue_en;
    logic out_load;
    logic sweep_done;
    logic load_ok;

    // scaler link
    scale_req_t       scale_req;
    scale_rsp_t       scale_rsp;
    logic             scale_busy;
    logic [LVL_W-1:0] span;

    // phase tick helpers
    logic [PHASE_W-1:0]  phase_inc;
    logic [CHANNELS-1:0] hit_mask;

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // a sync edge with playback enabled refreshes every fire count
                if (item_mode_reg == MODE_SYNC && sample_count_reg != '0)
                    state_next = ST_SWEEP;
                else
                    state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait only for the output register, never for the input side
                if (!out_vld_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        exec_en       = 1'b0;
        issue_en      = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_EXEC:  exec_en       = 1'b1;
            ST_SWEEP: issue_en      = (issue_cnt_reg != CNT_W'(CHANNELS));
            ST_DONE:  out_load      = !out_vld_reg || m_axis_tready;
            default:  ;
        endcase
    end

    // sweep ends once all reads are issued and nothing is left in flight
    assign sweep_done = (issue_cnt_reg == CNT_W'(CHANNELS)) && !rd_vld_reg && !scale_busy;

    // ---------------- item capture ----------------
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_mode_reg <= mode_t'(s_axis_tuser);
            item_ch_reg   <= s_axis_tdata[0 +: CH_W];
            item_idx_reg  <= s_axis_tdata[CH_W +: IDX_W];
            item_lvl_reg  <= s_axis_tdata[CH_W + IDX_W +: LVL_W];
        end
    end

    // ---------------- phase tick compare ----------------
    always_comb
    begin
        phase_inc = (phase_reg != PHASE_MAX) ? phase_reg + PHASE_W'(1) : phase_reg;
        for (int c = 0; c < CHANNELS; c++)
            hit_mask[c] = (PHASE_W'(fire_reg[c]) == phase_inc);
    end

    // ---------------- table memory ----------------
    assign load_ok  = (32'(item_ch_reg) < 32'(CHANNELS)) && (32'(item_idx_reg) < 32'(SAMPLES));
    assign mem_we   = exec_en && item_mode_reg == MODE_LOAD && load_ok;
    // load address while a load item is written, otherwise the sweep read of the current position
    assign mem_addr = mem_we ? {item_ch_reg, item_idx_reg[SMP_W-1:0]}
                             : {issue_cnt_reg[CH_W-1:0], position_reg[SMP_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_addr] <= item_lvl_reg;
        rd_data_reg <= table_mem[mem_addr];
    end

    // ---------------- fire count scaling ----------------
    // a max below min collapses the span to zero
    assign span = (fire_hi_reg < fire_lo_reg) ? '0 : fire_hi_reg - fire_lo_reg;

    assign scale_req.vld   = rd_vld_reg;
    assign scale_req.ch    = rd_ch_reg;
    assign scale_req.level = rd_data_reg;

    pdp_fire_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req),
        .span  (span),
        .rsp   (scale_rsp),
        .busy  (scale_busy)
    );

    always_ff @(posedge clk)
    begin
        rd_ch_reg <= issue_cnt_reg[CH_W-1:0];
    end

    // ---------------- playback state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            fire_lo_reg      <= '0;
            fire_hi_reg      <= {LVL_W{1'b1}};
            play_reg         <= PLAY_STOPPED;
            position_reg     <= '0;
            phase_reg        <= '0;
            pins_reg         <= '0;
            issue_cnt_reg    <= '0;
            rd_vld_reg       <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                fire_reg[c] <= '0;
        end
        else
        begin
            // configuration writes, unknown indexes dropped
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[SCNT_W-1:0];
                    CFG_FIRE_LO:      fire_lo_reg      <= cfg_data[LVL_W-1:0];
                    CFG_FIRE_HI:      fire_hi_reg      <= cfg_data[LVL_W-1:0];
                    default:          ;
                endcase
            end

            rd_vld_reg <= issue_en;
            if (issue_en)
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);

            if (scale_rsp.vld)
                fire_reg[scale_rsp.ch] <= LVL_W'(fire_lo_reg + scale_rsp.quot);

            if (exec_en)
            begin
                unique case (item_mode_reg)
                    MODE_PHASE:
                    begin
                        phase_reg <= phase_inc;
                        pins_reg  <= pins_reg | hit_mask;
                    end
                    MODE_SYNC:
                    begin
                        pins_reg <= (play_reg == PLAY_STOPPED) ? '1 : '0;
                        if (sample_count_reg != '0)
                        begin
                            // loop end wraps and resumes, also from pause
                            if (SCNT_W'(position_reg) >= sample_count_reg)
                            begin
                                position_reg <= '0;
                                play_reg     <= PLAY_RUNNING;
                            end
                            phase_reg     <= '0;
                            issue_cnt_reg <= '0;
                        end
                    end
                    MODE_MS:
                    begin
                        if (play_reg == PLAY_RUNNING && position_reg != POS_MAX)
                            position_reg <= position_reg + POS_W'(1);
                    end
                    MODE_LOAD: ;
                    MODE_PLAY:
                    begin
                        if (play_reg == PLAY_STOPPED)
                        begin
                            position_reg <= '0;
                            play_reg     <= PLAY_RUNNING;
                        end
                        else if (play_reg == PLAY_PAUSED)
                            play_reg <= PLAY_RUNNING;
                    end
                    MODE_PAUSE:
                    begin
                        if (play_reg == PLAY_RUNNING)
                            play_reg <= PLAY_PAUSED;
                    end
                    MODE_STOP:
                    begin
                        play_reg     <= PLAY_STOPPED;
                        position_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {(OUT_DATA_W - OUT_BITS)'(0), phase_reg, position_reg,
                             play_reg, pins_reg};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // the sweep may only finish with the scaling pipe drained
    a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && state_next != ST_SWEEP) |-> !scale_busy && !rd_vld_reg)
        else $error("sweep left with fire counts still in flight");

    // fire counts are only rewritten during a sweep
    a_rsp_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        scale_rsp.vld |-> state_reg == ST_SWEEP)
        else $error("fire count update outside a sweep");

    // table writes never collide with sweep reads
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_EXEC && !issue_en)
        else $error("table write outside item execution");

    // a phase tick always leaves a nonzero counter
    a_phase_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_en && item_mode_reg == MODE_PHASE) |=> phase_reg != '0)
        else $error("phase counter did not advance");

endmodule

`default_nettype wire

// File: dv/phase_dimmer_playback_unit_test.sv
// self-checking testbench of the phase dimmer playback unit
`timescale 1ns / 1ps

module phase_dimmer_playback_unit_test;

    import pdp_pkg::*;

    // mode code that the block has to ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    // cycles to let pass once the last result is in: output latency plus a full sweep
    localparam int SETTLE_CYCLES = 2 * CHANNELS + 16;
    // items of random stimulus for each register setting
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_REPORTS = 40;

    // result fields, pins in the lowest bits
    typedef struct packed {
        logic [PHASE_W-1:0]  phase_count;
        logic [POS_W-1:0]    position;
        logic [PLAY_W-1:0]   play_state;
        logic [CHANNELS-1:0] pins;
    } dimmer_word_t;

    // tracks the dimmer state and holds the expected output transfers in order
    class dimmer_scoreboard;
        bit [LVL_W-1:0]     levels [CHANNELS * SAMPLES];
        bit                 loaded [CHANNELS * SAMPLES];
        bit [LVL_W-1:0]     fire [CHANNELS];
        bit [PHASE_W-1:0]   phase_cnt;
        bit [CHANNELS-1:0]  pins;
        play_t              play;
        bit [POS_W-1:0]     pos;
        bit [SCNT_W-1:0]    sample_count;
        bit [LVL_W-1:0]     fire_lo;
        bit [LVL_W-1:0]     fire_hi;
        dimmer_word_t       expected [$];
        int                 failures;
        int                 accepted;
        int                 checked;
        int                 sweeps;
        int                 loads;

        function new();
            foreach (fire[c])
                fire[c] = '0;
            phase_cnt    = '0;
            pins         = '0;
            play         = PLAY_STOPPED;
            pos          = '0;
            sample_count = '0;
            fire_lo      = '0;
            fire_hi      = 8'd255;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int value);
            case (idx)
                CFG_SAMPLE_COUNT: sample_count = SCNT_W'(value);
                CFG_FIRE_LO:      fire_lo      = LVL_W'(value);
                CFG_FIRE_HI:      fire_hi      = LVL_W'(value);
                default: ;
            endcase
        endfunction

        // table position a sync edge would read now, -1 when playback is off
        function int sweep_position();
            if (sample_count == 0)
                return -1;
            return (pos >= sample_count) ? 0 : int'(pos);
        endfunction

        // fire count: a bright level fires early, a dark one late
        function bit [LVL_W-1:0] fire_point(int lvl);
            int lo;
            int hi;
            lo = fire_lo;
            hi = (fire_hi < fire_lo) ? fire_lo : fire_hi;
            return LVL_W'(lo + ((LEVEL_FS - lvl) * (hi - lo)) / LEVEL_FS);
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                                 logic [IDX_W-1:0] idx, logic [LVL_W-1:0] lvl);
            dimmer_word_t word;
            accepted++;
            case (mode)
                MODE_PHASE:
                begin
                    if (phase_cnt != PHASE_MAX)
                        phase_cnt++;
                    foreach (fire[c])
                        if (phase_cnt == PHASE_W'(fire[c]))
                            pins[c] = 1'b1;
                end
                MODE_SYNC:
                begin
                    pins = (play == PLAY_STOPPED) ? '1 : '0;
                    if (sample_count != 0)
                    begin
                        // loop end restarts playback, even from pause
                        if (pos >= sample_count)
                        begin
                            pos  = '0;
                            play = PLAY_RUNNING;
                        end
                        foreach (fire[c])
                            fire[c] = fire_point(levels[c * SAMPLES + pos]);
                        phase_cnt = '0;
                        sweeps++;
                    end
                end
                MODE_MS:
                    if (play == PLAY_RUNNING && pos != POS_MAX)
                        pos++;
                MODE_LOAD:
                begin
                    levels[{ch, idx}] = lvl;
                    loaded[{ch, idx}] = 1'b1;
                    loads++;
                end
                MODE_PLAY:
                    if (play == PLAY_STOPPED)
                    begin
                        pos  = '0;
                        play = PLAY_RUNNING;
                    end
                    else if (play == PLAY_PAUSED)
                        play = PLAY_RUNNING;
                MODE_PAUSE:
                    if (play == PLAY_RUNNING)
                        play = PLAY_PAUSED;
                MODE_STOP:
                begin
                    play = PLAY_STOPPED;
                    pos  = '0;
                end
                default: ;
            endcase
            word.pins        = pins;
            word.play_state  = play;
            word.position    = pos;
            word.phase_count = phase_cnt;
            expected = {expected, word};
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            dimmer_word_t got;
            dimmer_word_t want;
            got = data[OUT_BITS-1:0];
            if (expected.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, expected none, actual 0x%0h",
                             $time, data);
                return;
            end
            want = expected.pop_front();
            checked++;
            compare_field("pins", want.pins, got.pins);
            compare_field("play_state", want.play_state, got.play_state);
            compare_field("position", want.position, got.position);
            compare_field("phase_count", want.phase_count, got.phase_count);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // channel, sample_index, level (from bit 0 up)
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // mode
    logic [MODE_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // pins, play_state, position, phase_count (from bit 0 up)
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    dimmer_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    phase_dimmer_playback_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random, one draw per cycle
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // every output transfer is checked against the oldest expectation
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // half the time a level extreme, otherwise anything in range
    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(3))
            0: return '0;
            1: return LEVEL_FS_L;
            default: return LVL_W'($urandom_range(255));
        endcase
    endfunction

    // one input transfer; tvalid stays high into the next item unless a gap is drawn
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input logic [LVL_W-1:0] lvl);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({lvl, idx, ch});
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(mode, ch, idx, lvl);
    endtask

    // non-load items carry random noise in the unused fields
    task automatic send_op(input logic [MODE_W-1:0] mode);
        send_item(mode, CH_W'($urandom_range(7)), IDX_W'($urandom_range(4095)),
                  LVL_W'($urandom_range(255)));
    endtask

    // a sync edge, preceded by loads of any table entry it would read unwritten
    task automatic send_sync();
        int p;
        p = sb.sweep_position();
        if (p >= 0)
            for (int c = 0; c < CHANNELS; c++)
                if (!sb.loaded[c * SAMPLES + p])
                    send_item(MODE_LOAD, CH_W'(c), IDX_W'(p), pick_level());
        send_op(MODE_SYNC);
    endtask

    // lower tvalid and wait for every expected result, then for the block to settle
    task automatic wait_results_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_settings(input int scount, input int lmin, input int lmax);
        wait_results_idle();
        write_reg(CFG_SAMPLE_COUNT, scount);
        write_reg(CFG_FIRE_LO, lmin);
        write_reg(CFG_FIRE_HI, lmax);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random traffic: mostly mains half-cycles (sync then phase ticks), the rest single ops
    task automatic run_random(input int count);
        int done;
        int ticks;
        logic [MODE_W-1:0] op;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(99) < 55)
            begin
                send_sync();
                ticks = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
                repeat (ticks)
                    send_op(($urandom_range(9) == 0) ? MODE_MS : MODE_PHASE);
                done += ticks + 1;
            end
            else
            begin
                op = MODE_W'($urandom_range(7));
                if (op == MODE_SYNC)
                    send_sync();
                else if (op == MODE_LOAD)
                    send_item(MODE_LOAD, CH_W'($urandom_range(7)),
                              IDX_W'($urandom_range(4095)), pick_level());
                else
                    send_op(op);
                if (op != MODE_UNUSED)
                    done++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings, playback off
        send_item(MODE_UNUSED, '1, '1, '1);
        send_op(MODE_SYNC);                 // stopped: all pins high, no sweep
        send_op(MODE_PHASE);
        send_op(MODE_PLAY);                 // start from stopped
        send_op(MODE_MS);
        send_op(MODE_PAUSE);
        send_op(MODE_MS);                   // paused: position holds
        send_op(MODE_PLAY);                 // resume
        send_op(MODE_PLAY);                 // already running
        send_op(MODE_STOP);
        send_item(MODE_LOAD, '1, '1, LEVEL_FS_L);
        send_item(MODE_LOAD, '0, '0, '0);

        // loop end reached while paused
        write_settings(2, 0, 255);
        send_op(MODE_PLAY);
        send_op(MODE_MS);
        send_op(MODE_MS);
        send_op(MODE_PAUSE);
        send_sync();
        repeat (3) send_op(MODE_PHASE);
        send_sync();

        // busy sender, slow receiver
        send_idle_pct = 9;
        recv_idle_pct = 65;
        write_settings(8, 0, 20);
        run_random(RANDOM_ITEMS);
        write_settings(0, 3, 9);            // playback disabled
        run_random(RANDOM_ITEMS);

        // slow sender, busy receiver
        send_idle_pct = 65;
        recv_idle_pct = 9;
        write_settings(3, 12, 4);           // upper fire count below the lower one
        run_random(RANDOM_ITEMS);
        write_settings(1, 255, 255);
        run_random(RANDOM_ITEMS);

        // no idling: full table range, a playback stretch and a tick run past every fire count
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings(4096, 0, 255);
        send_op(MODE_STOP);
        send_op(MODE_PLAY);
        repeat (20) send_op(MODE_MS);
        send_sync();
        repeat (260) send_op(MODE_PHASE);
        run_random(RANDOM_ITEMS);
        write_settings(5, 0, 40);
        run_random(RANDOM_ITEMS);

        wait_results_idle();
        $display("run covered %0d input transfers and %0d checked results,",
                 sb.accepted, sb.checked);
        $display("with %0d table sweeps on sync edges and %0d table loads",
                 sb.sweeps, sb.loads);
        if (sb.failures == 0 && sb.expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: phase_dimmer_playback_unit.f
rtl/core/pdp_pkg.sv
rtl/core/pdp_fire_scale.sv
rtl/core/phase_dimmer_playback_unit.sv
dv/phase_dimmer_playback_unit_test.sv
